// ===== design/psa_pkg.sv =====
// Package with the opcode type and shared helpers of the packed SIMD ALU.
`timescale 1ns / 1ps
`default_nettype none
package psa_pkg;
	typedef enum logic [4:0] {
		OP_ADDB = 5'd0, OP_ADDW = 5'd1, OP_ADDD = 5'd2, OP_ADDQ = 5'd3,
		OP_SUBB = 5'd4, OP_SUBW = 5'd5, OP_SUBD = 5'd6, OP_SUBQ = 5'd7,
		OP_AND = 5'd8, OP_OR = 5'd9, OP_XOR = 5'd10,
		OP_EQB = 5'd11, OP_EQW = 5'd12, OP_EQD = 5'd13,
		OP_GTB = 5'd14, OP_GTW = 5'd15, OP_GTD = 5'd16,
		OP_SRLW = 5'd17, OP_SRLD = 5'd18, OP_SRLQ = 5'd19,
		OP_SLLW = 5'd20, OP_SLLD = 5'd21, OP_SLLQ = 5'd22,
		OP_SRAW = 5'd23, OP_SRAD = 5'd24,
		OP_MULH = 5'd25, OP_MULL = 5'd26, OP_MULUD = 5'd27,
		OP_UNPL = 5'd28, OP_SHUF = 5'd29, OP_MASK = 5'd30, OP_INS = 5'd31
	} op_t;

	localparam int NumLanes = 4;

	// Per-lane product of one stage-1 multiply lane.
	typedef struct packed {
		logic [31:0] wprod;
		logic [31:0] dprod;
	} lane_prod_t;
endpackage
`default_nettype wire

// ===== design/packed_simd_alu_64.sv =====
// Top level of the 64-bit packed SIMD integer ALU.
`timescale 1ns / 1ps
`default_nettype none
// Usage: drive cmd, src_operand, dst_operand, imm_value and use_imm and pulse
// start. Since busy is always low, an item is accepted at every edge where
// start is high, so one item may enter in every cycle.
// The block is a two-stage pipeline. Stage one registers the opcode, the
// result of the simple operations, and four 16-bit multiply lanes. Each lane
// forms a signed word product and one 16x16 partial product of the unsigned
// dword multiply. Stage two merges the lanes: it picks the high or low half
// of each word product, or sums the four partial products into the 64-bit
// dword product.
// The result is on the result port with done high for exactly one cycle,
// once the item has passed the stage-one registers and the result register.
// Throughput is one item per cycle. The receiver cannot stall, so nothing is
// ever held back.
// Reset clears the valid pipeline bits; no item is in flight afterward.
module packed_simd_alu_64 import psa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  cmd,
	input  wire logic [63:0] src_operand,
	input  wire logic [63:0] dst_operand,
	input  wire logic [7:0]  imm_value,
	input  wire logic        use_imm,
	output logic             done,
	output logic [63:0]      result
);
	logic        vld_s1, vld_s2;
	op_t         op_s1;
	logic [63:0] simple_r, simple_s1;
	lane_prod_t  prod_s1 [NumLanes];
	logic [15:0] ua [NumLanes];
	logic [15:0] ub [NumLanes];

	// Lanes 0..3 of the dword multiply: a0b0, a1b0, a0b1, a1b1.
	assign ua[0] = dst_operand[15:0];
	assign ub[0] = src_operand[15:0];
	assign ua[1] = dst_operand[31:16];
	assign ub[1] = src_operand[15:0];
	assign ua[2] = dst_operand[15:0];
	assign ub[2] = src_operand[31:16];
	assign ua[3] = dst_operand[31:16];
	assign ub[3] = src_operand[31:16];

	assign busy = 1'b0;

	psa_simple u_simple (
		.op      (op_t'(cmd)),
		.s       (src_operand),
		.d       (dst_operand),
		.imm     (imm_value),
		.use_imm (use_imm),
		.r       (simple_r)
	);

	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		psa_lane u_lane (
			.clk     (clk),
			.a       (dst_operand[g*16 +: 16]),
			.b       (src_operand[g*16 +: 16]),
			.ua      (ua[g]),
			.ub      (ub[g]),
			.prod_s1 (prod_s1[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= op_t'(cmd);
		simple_s1 <= simple_r;
	end

	// Merge stage: select word product halves or sum the dword partials.
	always_ff @(posedge clk) begin
		case (op_s1)
			OP_MULH: for (int i = 0; i < NumLanes; i++)
				result[i*16 +: 16] <= prod_s1[i].wprod[31:16];
			OP_MULL: for (int i = 0; i < NumLanes; i++)
				result[i*16 +: 16] <= prod_s1[i].wprod[15:0];
			OP_MULUD: result <= {32'd0, prod_s1[0].dprod}
				+ {16'd0, prod_s1[1].dprod, 16'd0}
				+ {16'd0, prod_s1[2].dprod, 16'd0}
				+ {prod_s1[3].dprod, 32'd0};
			default: result <= simple_s1;
		endcase
	end

	assign done = vld_s2;
endmodule
`default_nettype wire

// ===== design/psa_lane.sv =====
// One 16-bit lane: signed word multiply and a 16x16 slice of the dword multiply.
`timescale 1ns / 1ps
`default_nettype none
module psa_lane import psa_pkg::*; (
	input  wire logic        clk,
	input  wire logic [15:0] a,
	input  wire logic [15:0] b,
	input  wire logic [15:0] ua,
	input  wire logic [15:0] ub,
	output lane_prod_t       prod_s1
);
	// Registered so that the merge stage adds only registered products.
	always_ff @(posedge clk) begin
		prod_s1.wprod <= 32'($signed(a) * $signed(b));
		prod_s1.dprod <= 32'(ua) * 32'(ub);
	end
endmodule
`default_nettype wire

// ===== design/psa_simple.sv =====
// Combinational non-multiply operations of the packed SIMD ALU.
`timescale 1ns / 1ps
`default_nettype none
module psa_simple import psa_pkg::*; (
	input  wire op_t         op,
	input  wire logic [63:0] s,
	input  wire logic [63:0] d,
	input  wire logic [7:0]  imm,
	input  wire logic        use_imm,
	output logic [63:0]      r
);
	logic [63:0] cnt;
	logic        big_w, big_d, big_q;
	logic [3:0]  c4;
	logic [4:0]  c5;
	logic [5:0]  c6;

	assign cnt   = use_imm ? {56'd0, imm} : s;
	assign big_w = |cnt[63:4];
	assign big_d = |cnt[63:5];
	assign big_q = |cnt[63:6];
	assign c4    = cnt[3:0];
	assign c5    = cnt[4:0];
	assign c6    = cnt[5:0];

	always_comb begin
		r = '0;
		case (op)
			OP_ADDB: for (int i = 0; i < 8; i++) r[i*8 +: 8] = d[i*8 +: 8] + s[i*8 +: 8];
			OP_ADDW: for (int i = 0; i < 4; i++) r[i*16 +: 16] = d[i*16 +: 16] + s[i*16 +: 16];
			OP_ADDD: for (int i = 0; i < 2; i++) r[i*32 +: 32] = d[i*32 +: 32] + s[i*32 +: 32];
			OP_ADDQ: r = d + s;
			OP_SUBB: for (int i = 0; i < 8; i++) r[i*8 +: 8] = d[i*8 +: 8] - s[i*8 +: 8];
			OP_SUBW: for (int i = 0; i < 4; i++) r[i*16 +: 16] = d[i*16 +: 16] - s[i*16 +: 16];
			OP_SUBD: for (int i = 0; i < 2; i++) r[i*32 +: 32] = d[i*32 +: 32] - s[i*32 +: 32];
			OP_SUBQ: r = d - s;
			OP_AND:  r = d & s;
			OP_OR:   r = d | s;
			OP_XOR:  r = d ^ s;
			OP_EQB: for (int i = 0; i < 8; i++) r[i*8 +: 8] = {8{d[i*8 +: 8] == s[i*8 +: 8]}};
			OP_EQW: for (int i = 0; i < 4; i++)
				r[i*16 +: 16] = {16{d[i*16 +: 16] == s[i*16 +: 16]}};
			OP_EQD: for (int i = 0; i < 2; i++)
				r[i*32 +: 32] = {32{d[i*32 +: 32] == s[i*32 +: 32]}};
			OP_GTB: for (int i = 0; i < 8; i++)
				r[i*8 +: 8] = {8{$signed(d[i*8 +: 8]) > $signed(s[i*8 +: 8])}};
			OP_GTW: for (int i = 0; i < 4; i++)
				r[i*16 +: 16] = {16{$signed(d[i*16 +: 16]) > $signed(s[i*16 +: 16])}};
			OP_GTD: for (int i = 0; i < 2; i++)
				r[i*32 +: 32] = {32{$signed(d[i*32 +: 32]) > $signed(s[i*32 +: 32])}};
			OP_SRLW: for (int i = 0; i < 4; i++)
				r[i*16 +: 16] = big_w ? 16'd0 : d[i*16 +: 16] >> c4;
			OP_SRLD: for (int i = 0; i < 2; i++)
				r[i*32 +: 32] = big_d ? 32'd0 : d[i*32 +: 32] >> c5;
			OP_SRLQ: r = big_q ? 64'd0 : d >> c6;
			OP_SLLW: for (int i = 0; i < 4; i++)
				r[i*16 +: 16] = big_w ? 16'd0 : d[i*16 +: 16] << c4;
			OP_SLLD: for (int i = 0; i < 2; i++)
				r[i*32 +: 32] = big_d ? 32'd0 : d[i*32 +: 32] << c5;
			OP_SLLQ: r = big_q ? 64'd0 : d << c6;
			OP_SRAW: for (int i = 0; i < 4; i++)
				r[i*16 +: 16] = $signed(d[i*16 +: 16]) >>> (big_w ? 4'd15 : c4);
			OP_SRAD: for (int i = 0; i < 2; i++)
				r[i*32 +: 32] = $signed(d[i*32 +: 32]) >>> (big_d ? 5'd31 : c5);
			OP_UNPL: r = {s[31:0], d[31:0]};
			OP_SHUF: for (int i = 0; i < 4; i++)
				r[i*16 +: 16] = s[imm[i*2 +: 2]*16 +: 16];
			OP_MASK: for (int i = 0; i < 8; i++) r[i] = s[i*8 + 7];
			OP_INS: begin
				r = d;
				r[imm[1:0]*16 +: 16] = s[15:0];
			end
			default: r = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 64-bit packed SIMD integer ALU.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import psa_pkg::*;

	// Clock, reset and the ports of the block.
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [4:0]  cmd;
	logic [63:0] src_operand;
	logic [63:0] dst_operand;
	logic [7:0]  imm_value;
	logic        use_imm;
	logic        done;
	logic [63:0] result;

	// Results still owed by the block, oldest first.
	logic [63:0] pending_results[$];
	int          mismatch_count;
	int          idle_cycles;
	int          items_sent;
	int          results_seen;
	// When set, the sender inserts random gaps between items.
	bit          gaps_on;

	packed_simd_alu_64 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.src_operand (src_operand),
		.dst_operand (dst_operand),
		.imm_value   (imm_value),
		.use_imm     (use_imm),
		.done        (done),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Extracts lane i of the given width.
	function automatic logic [63:0] lane_of(logic [63:0] v, int bits, int i);
		logic [63:0] m;
		m = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
		return (v >> (bits * i)) & m;
	endfunction

	// Computes the packed result of one operation, lane by lane.
	function automatic logic [63:0] alu_result(logic [4:0] op, logic [63:0] s,
			logic [63:0] d, logic [7:0] imm, logic ui);
		logic [63:0] r, m, a, b, x, sgn, cnt;
		logic signed [63:0] sa, sb;
		int bits, n, kind;
		r = '0;
		cnt = ui ? {56'd0, imm} : s;
		case (op_t'(op))
			OP_ADDB, OP_ADDW, OP_ADDD, OP_ADDQ,
			OP_SUBB, OP_SUBW, OP_SUBD, OP_SUBQ,
			OP_EQB, OP_EQW, OP_EQD, OP_GTB, OP_GTW, OP_GTD: begin
				if (op <= OP_SUBQ) begin
					bits = 8 << (op % 4);
					kind = (op >= OP_SUBB) ? 1 : 0;
				end else if (op <= OP_EQD) begin
					bits = 8 << (op - OP_EQB);
					kind = 2;
				end else begin
					bits = 8 << (op - OP_GTB);
					kind = 3;
				end
				m = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
				sgn = 64'd1 << (bits - 1);
				n = 64 / bits;
				for (int i = 0; i < n; i++) begin
					a = lane_of(d, bits, i);
					b = lane_of(s, bits, i);
					case (kind)
						0: x = a + b;
						1: x = a - b;
						2: x = (a == b) ? m : '0;
						default: x = ((a ^ sgn) > (b ^ sgn)) ? m : '0;
					endcase
					r |= (x & m) << (bits * i);
				end
			end
			OP_AND: r = d & s;
			OP_OR:  r = d | s;
			OP_XOR: r = d ^ s;
			OP_SRLW, OP_SRLD, OP_SRLQ, OP_SLLW, OP_SLLD, OP_SLLQ, OP_SRAW, OP_SRAD: begin
				if (op <= OP_SRLQ) begin
					bits = 16 << (op - OP_SRLW);
					kind = 0;
				end else if (op <= OP_SLLQ) begin
					bits = 16 << (op - OP_SLLW);
					kind = 1;
				end else begin
					bits = 16 << (op - OP_SRAW);
					kind = 2;
				end
				m = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
				sgn = 64'd1 << (bits - 1);
				n = 64 / bits;
				for (int i = 0; i < n; i++) begin
					a = lane_of(d, bits, i);
					// Counts past the lane width clear or sign-fill the lane.
					if (cnt > bits - 1)
						x = (kind == 2 && (a & sgn) != 0) ? m : '0;
					else if (kind == 0)
						x = a >> cnt[5:0];
					else if (kind == 1)
						x = (a << cnt[5:0]) & m;
					else begin
						x = a >> cnt[5:0];
						if ((a & sgn) != 0)
							x |= m & ~(m >> cnt[5:0]);
					end
					r |= x << (bits * i);
				end
			end
			OP_MULH, OP_MULL: begin
				for (int i = 0; i < 4; i++) begin
					sa = {{48{d[16*i+15]}}, d[16*i +: 16]};
					sb = {{48{s[16*i+15]}}, s[16*i +: 16]};
					x = sa * sb;
					r[16*i +: 16] = (op == OP_MULH) ? x[31:16] : x[15:0];
				end
			end
			OP_MULUD: r = {32'd0, d[31:0]} * {32'd0, s[31:0]};
			OP_UNPL:  r = {s[31:0], d[31:0]};
			OP_SHUF: begin
				for (int i = 0; i < 4; i++)
					r[16*i +: 16] = s[16*imm[2*i +: 2] +: 16];
			end
			OP_MASK: begin
				for (int i = 0; i < 8; i++)
					r[i] = s[8*i+7];
			end
			default: begin
				r = d;
				r[16*imm[1:0] +: 16] = s[15:0];
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
	endtask

	// Sends one item: drives it at a falling edge, holds start until accepted.
	// Start stays high after acceptance so that the next item can follow at
	// once; it drops only when a gap is taken or the run ends.
	task automatic send_item(logic [4:0] op, logic [63:0] s, logic [63:0] d,
			logic [7:0] imm, logic ui);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		cmd <= op;
		src_operand <= s;
		dst_operand <= d;
		imm_value <= imm;
		use_imm <= ui;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(alu_result(op, s, d, imm, ui));
		items_sent++;
		@(negedge clk);
	endtask

	// Draws a 64-bit value that is often an extreme or a lane boundary.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'h8080_8080_8080_8080;
			3: return 64'h7fff_8000_7fff_ffff;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Draws a shift count: mostly in range, some past every lane width.
	function automatic logic [63:0] pick_count();
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(14, 66));
			default: return 64'($urandom_range(0, 63));
		endcase
	endfunction

	// Checks each result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0)
				report_mismatch("unexpected result", result, '0);
			else if (result !== pending_results[0]) begin
				report_mismatch("result", result, pending_results[0]);
				void'(pending_results.pop_front());
			end else
				void'(pending_results.pop_front());
		end
	end

	// Watchdog: ends the run after a long stretch with no item and no result.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Every operation on extreme operands.
	task automatic test_every_operation();
		for (int op = 0; op < 32; op++)
			send_item(5'(op), '1, 64'h8000_0000_0000_0001, 8'hff, 1'b0);
		send_item(OP_MASK, 64'h80_7f_ff_00_80_01_ff_00, '0, 8'h00, 1'b1);
	endtask

	// Oversized and largest in-range shift counts, by immediate and by the whole source operand.
	task automatic test_oversized_shifts();
		send_item(OP_SRAW, '0, 64'h8000_7fff_ffff_0001, 8'd16, 1'b1);
		send_item(OP_SRAD, 64'h1_0000_0000, 64'h8000_0000_0000_0001, 8'd0, 1'b0);
		send_item(OP_SRLQ, 64'd64, '1, 8'd0, 1'b0);
		send_item(OP_SLLW, '0, '1, 8'd15, 1'b1);
		send_item(OP_SRAD, '0, 64'h8000_0000_0000_0001, 8'd31, 1'b1);
	endtask

	// Insert uses only the low two bits of the index; shuffle uses all eight.
	task automatic test_insert_and_shuffle();
		send_item(OP_INS, 64'h1234, '0, 8'hfe, 1'b0);
		send_item(OP_INS, 64'hffff_abcd, '1, 8'h03, 1'b1);
		send_item(OP_SHUF, 64'h4444_3333_2222_1111, '0, 8'h1b, 1'b0);
	endtask

	// Random items, with random gaps between them when with_gaps is set.
	task automatic test_random_items(int count, bit with_gaps);
		logic [4:0] op;
		logic       ui;
		gaps_on = with_gaps;
		repeat (count) begin
			op = 5'($urandom);
			ui = 1'($urandom);
			if (op >= OP_SRLW && op <= OP_SRAD && !ui)
				send_item(op, pick_count(), pick_operand(), 8'($urandom), ui);
			else if (op >= OP_SRLW && op <= OP_SRAD)
				send_item(op, pick_operand(), pick_operand(),
					8'(pick_count()), ui);
			else
				send_item(op, pick_operand(), pick_operand(), 8'($urandom), ui);
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		src_operand = '0;
		dst_operand = '0;
		imm_value = '0;
		use_imm = 1'b0;
		gaps_on = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		results_seen = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_every_operation();
		test_oversized_shifts();
		test_insert_and_shuffle();
		test_random_items(310, 1'b1);
		test_random_items(100, 1'b0);
		start <= 1'b0;

		// Drain the pipeline, then keep watching for stray results.
		waited = 0;
		while (pending_results.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		$display("Sent %0d items over all 32 operations, checked %0d results.",
			items_sent, results_seen);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
design/psa_pkg.sv
design/psa_lane.sv
design/psa_simple.sv
design/packed_simd_alu_64.sv
tb/tb_top.sv
